@@ src/linear_scan_priority_queue_defines.svh @@
// Assertion helpers for the checker file.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_DEFINES_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define LSQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define LSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lsq_pkg.sv @@
package lsq_pkg;

  localparam int unsigned LSQ_DEPTH = 1024;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ENTRY_W   = 2 * DATA_W;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted beat, rewind the read pointer
    logic scan;        // stream entries through the top-entry compare
    logic shift_init;  // point the read pointer just past the top entry
    logic shift;       // move each later entry down one slot
    logic emit;        // load the result register and commit the count
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_needed;
    logic is_deq;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/lsq_ctrl.sv @@
module lsq_ctrl
  import lsq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DISP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = sts.scan_needed ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.is_deq) begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the result register can take the beat
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/lsq_datapath.sv @@
module lsq_datapath
  import lsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = LSQ_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]   in_item_value,
  input  logic [DATA_W-1:0]   in_item_priority,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_top_value,
  output logic [DATA_W-1:0]   out_top_priority,
  output logic [STAT_W-1:0]   out_status,
  output logic [CNT_W-1:0]    out_occupancy
);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

  logic [CNT_W-1:0]   count_r, count_nxt;
  req_t               req_r, req_nxt;
  logic [ENTRY_W-1:0] ent_r, ent_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               dv_r, dv_nxt;
  logic [IDX_W-1:0]   didx_r, didx_nxt;
  logic [ENTRY_W-1:0] rdata_r;
  logic [ENTRY_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic               best_v_r, best_v_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  top_val_r, top_val_nxt;
  logic [DATA_W-1:0]  top_pri_r, top_pri_nxt;
  status_t            stat_r, stat_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic               is_full;
  logic               is_empty;
  logic               is_top_req;
  logic               better;

  assign is_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty   = (count_r == '0);
  assign is_top_req = (req_r == REQ_DEQ) || (req_r == REQ_PEEK);

  // Higher signed priority wins, then higher signed value; earlier entry keeps a full tie.
  assign better = !best_v_r
               || ($signed(rdata_r[ENTRY_W-1:DATA_W]) > $signed(best_r[ENTRY_W-1:DATA_W]))
               || (($signed(rdata_r[ENTRY_W-1:DATA_W]) == $signed(best_r[ENTRY_W-1:DATA_W]))
                   && ($signed(rdata_r[DATA_W-1:0]) > $signed(best_r[DATA_W-1:0])));

  always_comb begin
    count_nxt     = count_r;
    req_nxt       = req_r;
    ent_nxt       = ent_r;
    ptr_nxt       = ptr_r;
    dv_nxt        = dv_r;
    didx_nxt      = didx_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    best_v_nxt    = best_v_r;
    out_valid_nxt = out_valid_r;
    top_val_nxt   = top_val_r;
    top_pri_nxt   = top_pri_r;
    stat_nxt      = stat_r;
    occ_nxt       = occ_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = ent_r;

    if (cmd.load) begin
      req_nxt    = req_t'(in_req_type);
      ent_nxt    = {in_item_priority, in_item_value};
      ptr_nxt    = '0;
      dv_nxt     = 1'b0;
      best_v_nxt = 1'b0;
    end

    // Issue one read a cycle while entries remain; the data is registered in rdata_r.
    if (cmd.scan || cmd.shift) begin
      if (ptr_r < count_r) begin
        rd_en    = 1'b1;
        ptr_nxt  = ptr_r + CNT_W'(1);
        dv_nxt   = 1'b1;
        didx_nxt = ptr_r[IDX_W-1:0];
      end else begin
        dv_nxt = 1'b0;
      end
    end

    if (cmd.scan && dv_r && better) begin
      best_nxt     = rdata_r;
      best_idx_nxt = didx_r;
      best_v_nxt   = 1'b1;
    end

    if (cmd.shift && dv_r) begin
      wr_en   = 1'b1;
      wr_addr = didx_r - IDX_W'(1);
      wr_data = rdata_r;
    end

    // Takes the final compare of the scan into account.
    if (cmd.shift_init) begin
      ptr_nxt = CNT_W'(best_idx_nxt) + CNT_W'(1);
      dv_nxt  = 1'b0;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      top_val_nxt   = '0;
      top_pri_nxt   = '0;
      stat_nxt      = ST_OK;
      occ_nxt       = count_r;
      if (req_r == REQ_ENQ) begin
        if (is_full) begin
          stat_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = count_r[IDX_W-1:0];
          wr_data   = ent_r;
          count_nxt = count_r + CNT_W'(1);
          occ_nxt   = count_nxt;
        end
      end else if (is_top_req) begin
        if (is_empty) begin
          stat_nxt = ST_EMPTY;
        end else begin
          top_val_nxt = best_r[DATA_W-1:0];
          top_pri_nxt = best_r[ENTRY_W-1:DATA_W];
          if (req_r == REQ_DEQ) begin
            count_nxt = count_r - CNT_W'(1);
            occ_nxt   = count_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      req_r       <= REQ_NONE;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      req_r       <= req_nxt;
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      best_v_r    <= best_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    didx_r     <= didx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    top_val_r  <= top_val_nxt;
    top_pri_r  <= top_pri_nxt;
    stat_r     <= stat_nxt;
    occ_r      <= occ_nxt;
  end

  assign sts.scan_needed = is_top_req && !is_empty;
  assign sts.is_deq      = (req_r == REQ_DEQ);
  assign sts.scan_done   = dv_r && (CNT_W'(didx_r) == (count_r - CNT_W'(1)));
  assign sts.shift_done  = !dv_r && (ptr_r >= count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_top_value    = top_val_r;
  assign out_top_priority = top_pri_r;
  assign out_status       = stat_r;
  assign out_occupancy    = occ_r;

endmodule

@@ src/linear_scan_priority_queue.sv @@
// Priority queue over an unsorted entry memory of QUEUE_DEPTH (value, priority) pairs kept in
// arrival order. Requests go one at a time through a single-read, single-write memory, so the
// cost grows with the fill level n: an enqueue or a request code 3 skips the scan; a peek reads
// all n entries, one a cycle; a dequeue adds a move of the n - t - 1 entries behind the top
// entry at index t. Peek or dequeue on an empty queue and enqueue on a full one report status
// empty or full and leave the contents unchanged. A finished result sits in an output register,
// so the next request is taken while it waits for out_tready.
module linear_scan_priority_queue
  import lsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = LSQ_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_TDATA_W = ((2 * DATA_W + CNT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ENTRY_W-1:0]     in_tdata,   // item_value, item_priority
  input  logic [REQ_W-1:0]       in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // top_value, top_priority, occupancy, zero pad
  output logic [STAT_W-1:0]      out_tuser   // status
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [DATA_W-1:0]   top_value;
  logic [DATA_W-1:0]   top_priority;
  logic [CNT_W-1:0]    occupancy;

  lsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_tuser),
    .in_item_value    (in_tdata[DATA_W-1:0]),
    .in_item_priority (in_tdata[ENTRY_W-1:DATA_W]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_top_value    (top_value),
    .out_top_priority (top_priority),
    .out_status       (out_tuser),
    .out_occupancy    (occupancy)
  );

  assign out_tdata = OUT_TDATA_W'({occupancy, top_priority, top_value});

endmodule

@@ src/lsq_checker.sv @@
`include "linear_scan_priority_queue_defines.svh"

module lsq_checker
  import lsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = LSQ_DEPTH,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_TDATA_W = ((2 * DATA_W + CNT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  logic [CNT_W-1:0] occ;

  assign occ = out_tdata[2*DATA_W +: CNT_W];

  `LSQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result beat changed")
  `LSQ_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request accepted while another is in flight")
  `LSQ_ASSERT_SAME(a_empty_occ, out_tvalid && (out_tuser == ST_EMPTY), occ == '0, "empty status with entries held")
  `LSQ_ASSERT_SAME(a_full_occ, out_tvalid && (out_tuser == ST_FULL), occ == CNT_W'(QUEUE_DEPTH), "full status below depth")

endmodule

bind linear_scan_priority_queue lsq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lsq_checker (.*);
